// ===== hdl/set_assoc_fill_lru_fifo_defines.svh =====
// assertion macros for the set-associative replacement block
`ifndef SET_ASSOC_FILL_LRU_FIFO_DEFINES_SVH
`define SET_ASSOC_FILL_LRU_FIFO_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define SALF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked out of reset
`define SALF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define SALF_ASSERT_IMPL(lbl, ante, cons)
`define SALF_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== hdl/salf_pkg.sv =====
`timescale 1ns / 1ps

package salf_pkg;

  // geometry
  localparam int NUM_SETS = 64;
  localparam int NUM_WAYS = 8;
  localparam int TAG_BITS = 32;

  localparam int SET_W    = 6;
  localparam int WAY_W    = 3;
  localparam int RANK_W   = 3;
  localparam int LINE_W   = SET_W + WAY_W;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_USE_LRU     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd1;

  localparam logic [CFG_DATA_W-1:0] WAYS_RESET = CFG_DATA_W'(NUM_WAYS);

  typedef enum logic {
    CMD_FILL  = 1'b0,
    CMD_TOUCH = 1'b1
  } cmd_e;

  typedef enum logic {
    ST_IDLE,
    ST_PROC
  } state_e;

  // one set: round-robin pointer, recency ranks and valid bits
  typedef struct packed {
    logic [WAY_W-1:0]                ptr;
    logic [NUM_WAYS-1:0][RANK_W-1:0] rank;
    logic [NUM_WAYS-1:0]             valid;
  } row_t;

  typedef struct packed {
    logic             evicted;
    logic [WAY_W-1:0] way_used;
  } res_t;

endpackage

// ===== hdl/salf_row_mem.sv =====
`timescale 1ns / 1ps

module salf_row_mem (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [salf_pkg::SET_W-1:0]   rd_addr_i,
  output salf_pkg::row_t               rd_row_o,
  input  logic                         wr_en_i,
  input  logic [salf_pkg::SET_W-1:0]   wr_addr_i,
  input  salf_pkg::row_t               wr_row_i
);

  salf_pkg::row_t                  mem_q [salf_pkg::NUM_SETS];
  salf_pkg::row_t                  rd_data_q;
  logic [salf_pkg::NUM_SETS-1:0]   row_ok_q;
  logic                            rd_ok_q;

  // row storage, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_row_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // per-row written flags, a row never written reads as all zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_ok_q <= '0;
      rd_ok_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_ok_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_ok_q <= row_ok_q[rd_addr_i];
      end
    end
  end

  assign rd_row_o = rd_ok_q ? rd_data_q : '0;

endmodule

// ===== hdl/salf_tag_mem.sv =====
`timescale 1ns / 1ps

module salf_tag_mem (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [salf_pkg::LINE_W-1:0]   wr_addr_i,
  input  logic [salf_pkg::TAG_BITS-1:0] wr_data_i
);

  logic [salf_pkg::TAG_BITS-1:0] mem_q [salf_pkg::NUM_SETS * salf_pkg::NUM_WAYS];

  // tag store, one line per fill
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

endmodule

// ===== hdl/salf_repl.sv =====
`timescale 1ns / 1ps

module salf_repl (
  input  salf_pkg::cmd_e                  cmd_i,
  input  logic                            use_lru_i,
  input  logic [salf_pkg::CFG_DATA_W-1:0] ways_i,
  input  logic [salf_pkg::WAY_W-1:0]      way_i,
  input  salf_pkg::row_t                  row_i,
  output salf_pkg::row_t                  row_o,
  output salf_pkg::res_t                  res_o
);

  logic [salf_pkg::CFG_DATA_W-1:0] n;
  logic [salf_pkg::NUM_WAYS-1:0]   in_use;
  logic                            found;
  logic [salf_pkg::WAY_W-1:0]      free_way;
  logic [salf_pkg::WAY_W-1:0]      lru_way;
  logic [salf_pkg::RANK_W-1:0]     best;
  logic [salf_pkg::WAY_W-1:0]      fifo_way;
  logic [salf_pkg::CFG_DATA_W-1:0] fifo_inc;
  logic [salf_pkg::WAY_W-1:0]      fifo_next;
  logic                            recent;
  logic [salf_pkg::WAY_W-1:0]      recent_way;
  logic [salf_pkg::RANK_W-1:0]     old_rank;

  // clamp ways in use to 1..NUM_WAYS
  always_comb begin
    if (ways_i == '0) begin
      n = salf_pkg::CFG_DATA_W'(1);
    end else if (ways_i > salf_pkg::CFG_DATA_W'(salf_pkg::NUM_WAYS)) begin
      n = salf_pkg::CFG_DATA_W'(salf_pkg::NUM_WAYS);
    end else begin
      n = ways_i;
    end
    for (int j = 0; j < salf_pkg::NUM_WAYS; j++) begin
      in_use[j] = salf_pkg::CFG_DATA_W'(j) < n;
    end
  end

  // lowest invalid way in use
  always_comb begin
    found    = 1'b0;
    free_way = '0;
    for (int j = salf_pkg::NUM_WAYS - 1; j >= 0; j--) begin
      if (in_use[j] && !row_i.valid[j]) begin
        found    = 1'b1;
        free_way = salf_pkg::WAY_W'(j);
      end
    end
  end

  // least recent way, lowest index wins a tie
  always_comb begin
    lru_way = '0;
    best    = row_i.rank[0];
    for (int j = 1; j < salf_pkg::NUM_WAYS; j++) begin
      if (in_use[j] && (row_i.rank[j] < best)) begin
        best    = row_i.rank[j];
        lru_way = salf_pkg::WAY_W'(j);
      end
    end
  end

  // round-robin victim and pointer advance
  always_comb begin
    if (salf_pkg::CFG_DATA_W'(row_i.ptr) >= n) begin
      fifo_way = '0;
    end else begin
      fifo_way = row_i.ptr;
    end
    fifo_inc = salf_pkg::CFG_DATA_W'(fifo_way) + salf_pkg::CFG_DATA_W'(1);
    if (fifo_inc >= n) begin
      fifo_next = '0;
    end else begin
      fifo_next = fifo_inc[salf_pkg::WAY_W-1:0];
    end
  end

  // command decode, valid and pointer update
  always_comb begin
    row_o          = row_i;
    res_o.evicted  = 1'b0;
    res_o.way_used = way_i;
    recent         = 1'b0;
    recent_way     = way_i;
    unique case (cmd_i)
      salf_pkg::CMD_TOUCH: begin
        recent = salf_pkg::CFG_DATA_W'(way_i) < n;
      end
      salf_pkg::CMD_FILL: begin
        if (found) begin
          res_o.way_used         = free_way;
          row_o.valid[free_way]  = 1'b1;
        end else begin
          res_o.evicted = 1'b1;
          if (use_lru_i) begin
            res_o.way_used = lru_way;
          end else begin
            res_o.way_used = fifo_way;
            row_o.ptr      = fifo_next;
          end
        end
        recent     = use_lru_i;
        recent_way = res_o.way_used;
      end
      default: begin
        recent = 1'b0;
      end
    endcase

    // recency: chosen way goes to the top, ways above it drop one
    old_rank = row_i.rank[recent_way];
    if (recent) begin
      for (int j = 0; j < salf_pkg::NUM_WAYS; j++) begin
        if (in_use[j] && (salf_pkg::WAY_W'(j) != recent_way) && (row_i.rank[j] > old_rank)) begin
          row_o.rank[j] = row_i.rank[j] - salf_pkg::RANK_W'(1);
        end
      end
      row_o.rank[recent_way] = salf_pkg::RANK_W'(salf_pkg::NUM_WAYS - 1);
    end
  end

endmodule

// ===== hdl/set_assoc_fill_lru_fifo.sv =====
`timescale 1ns / 1ps

// Replacement bookkeeping for a 64-set, 8-way cache. A command is taken when start is high
// and busy is low: the set's row (valid bits, recency ranks, round-robin pointer) is read
// from a registered-read row RAM, then updated and written back in the next cycle, with
// busy high so that no new command is taken. The result (evicted_o, way_used_o) is shown
// for exactly one cycle with done_o high, in the cycle after the write-back; it cannot be
// held off, so the receiver must take it then. Fill tags go into a separate tag RAM. No
// clearing pass follows reset: per-row written flags make untouched sets read as empty.
// Configuration (cfg_ready_o is always high) must only be written while idle.
`include "set_assoc_fill_lru_fifo_defines.svh"

module set_assoc_fill_lru_fifo (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            cmd_i,
  input  logic [salf_pkg::SET_W-1:0]      set_index_i,
  input  logic [salf_pkg::TAG_BITS-1:0]   tag_i,
  input  logic [salf_pkg::WAY_W-1:0]      way_index_i,
  output logic                            done_o,
  output logic                            evicted_o,
  output logic [salf_pkg::WAY_W-1:0]      way_used_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [salf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [salf_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  salf_pkg::state_e                state_q, state_d;
  salf_pkg::cmd_e                  cmd_q;
  logic [salf_pkg::SET_W-1:0]      set_q;
  logic [salf_pkg::TAG_BITS-1:0]   tag_q;
  logic [salf_pkg::WAY_W-1:0]      way_q;
  logic                            use_lru_q;
  logic [salf_pkg::CFG_DATA_W-1:0] ways_q;
  logic                            done_q;
  salf_pkg::res_t                  res_q;

  logic                            accept;
  logic                            wr_en;
  salf_pkg::row_t                  rd_row;
  salf_pkg::row_t                  wr_row;
  salf_pkg::res_t                  res;

  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      salf_pkg::ST_IDLE: begin
        if (start) begin
          state_d = salf_pkg::ST_PROC;
        end
      end
      salf_pkg::ST_PROC: begin
        state_d = salf_pkg::ST_IDLE;
      end
      default: begin
        state_d = salf_pkg::ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    busy  = 1'b0;
    wr_en = 1'b0;
    unique case (state_q)
      salf_pkg::ST_IDLE: begin
        busy  = 1'b0;
        wr_en = 1'b0;
      end
      salf_pkg::ST_PROC: begin
        busy  = 1'b1;
        wr_en = 1'b1;
      end
      default: begin
        busy  = 1'b0;
        wr_en = 1'b0;
      end
    endcase
  end

  // control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= salf_pkg::ST_IDLE;
      done_q    <= 1'b0;
      use_lru_q <= 1'b1;
      ways_q    <= salf_pkg::WAYS_RESET;
    end else begin
      state_q <= state_d;
      done_q  <= wr_en;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == salf_pkg::CFG_USE_LRU) begin
          use_lru_q <= cfg_data_i[0];
        end else if (cfg_index_i == salf_pkg::CFG_WAYS_IN_USE) begin
          ways_q <= cfg_data_i;
        end
      end
    end
  end

  // command capture and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= salf_pkg::cmd_e'(cmd_i);
      set_q <= set_index_i;
      tag_q <= tag_i;
      way_q <= way_index_i;
    end
    if (wr_en) begin
      res_q <= res;
    end
  end

  salf_row_mem u_row_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (set_index_i),
    .rd_row_o  (rd_row),
    .wr_en_i   (wr_en),
    .wr_addr_i (set_q),
    .wr_row_i  (wr_row)
  );

  salf_repl u_repl (
    .cmd_i     (cmd_q),
    .use_lru_i (use_lru_q),
    .ways_i    (ways_q),
    .way_i     (way_q),
    .row_i     (rd_row),
    .row_o     (wr_row),
    .res_o     (res)
  );

  salf_tag_mem u_tag_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en && (cmd_q == salf_pkg::CMD_FILL)),
    .wr_addr_i ({set_q, res.way_used}),
    .wr_data_i (tag_q)
  );

  assign done_o     = done_q;
  assign evicted_o  = res_q.evicted;
  assign way_used_o = res_q.way_used;

  // checks
  `SALF_ASSERT_NEXT(a_accept_then_busy, start && !busy, busy)
  `SALF_ASSERT_NEXT(a_busy_then_done, busy, done_o && !busy)
  `SALF_ASSERT_IMPL(a_touch_never_evicts, wr_en && (cmd_q == salf_pkg::CMD_TOUCH), !res.evicted)

endmodule
